FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the delta-list scheduler rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked property, held off while reset is asserted
`define DLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked across reset
`define DLTS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLTS_ASSERT(lbl, prop, msg)
`define DLTS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/dlts_pkg.sv
// ---------------------------------------------------------------------------
// dlts_pkg
// shared types, codes and constants of the delta-list task scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package dlts_pkg;

  localparam int DLTS_MAX_TASKS = 16;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [7:0] RUNS_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_handle;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] run_handle;
    logic       run_valid;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  runs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_SH_RD,
    S_SH_WR,
    S_PUT_HOLD,
    S_PUT_NEW,
    S_TICK_RD,
    S_TICK_WR,
    S_DSP_RD,
    S_DSP_CHK,
    S_DSP_RD1,
    S_DSP_FIX,
    S_RM_RD,
    S_RM_WR,
    S_RM_DONE,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_WALK_NEXT,
    ACT_WALK_STOP,
    ACT_SHIFT_DN,
    ACT_PUT_HOLD,
    ACT_PUT_NEW,
    ACT_TICK,
    ACT_DSP_TAKE,
    ACT_DSP_FIX,
    ACT_SHIFT_UP,
    ACT_REMOVE
  } dp_act_t;

  typedef struct packed {
    dp_act_t act;
    logic    rd_src;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic walk_go;
    logic walk_in;
    logic sh_first;
    logic sh_more;
    logic runs_zero;
    logic multi;
    logic rm_start;
    logic rm_more;
    logic per_nz;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlts_ram.sv
// ---------------------------------------------------------------------------
// dlts_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module dlts_ram #(
  parameter int WIDTH = dlts_pkg::ENTRY_W,
  parameter int DEPTH = dlts_pkg::DLTS_MAX_TASKS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dlts_ctrl.sv
// ---------------------------------------------------------------------------
// dlts_ctrl
// sequencer for add, tick and dispatch over the task table
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dlts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output logic                   in_stall,
  input  wire dlts_pkg::dp_sts_t sts,
  output dlts_pkg::dp_cmd_t      cmd
);
  import dlts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority case (in_op)
            OP_ADD:      state_nxt = sts.full ? S_FIN : S_WALK_RD;
            OP_TICK:     state_nxt = sts.cnt_zero ? S_FIN : S_TICK_RD;
            OP_DISPATCH: state_nxt = sts.cnt_zero ? S_FIN : S_DSP_RD;
            default:     state_nxt = S_FIN;
          endcase
        end
      end
      S_WALK_RD:  state_nxt = S_WALK_CMP;
      S_WALK_CMP: begin
        priority if (sts.walk_go) begin
          state_nxt = S_WALK_RD;
        end else if (sts.walk_in) begin
          state_nxt = sts.sh_first ? S_SH_RD : S_PUT_HOLD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SH_RD:    state_nxt = S_SH_WR;
      S_SH_WR:    state_nxt = sts.sh_more ? S_SH_RD : S_PUT_HOLD;
      S_PUT_HOLD: state_nxt = S_PUT_NEW;
      S_PUT_NEW:  state_nxt = S_FIN;
      S_TICK_RD:  state_nxt = S_TICK_WR;
      S_TICK_WR:  state_nxt = S_FIN;
      S_DSP_RD:   state_nxt = S_DSP_CHK;
      S_DSP_CHK: begin
        priority if (sts.runs_zero) begin
          state_nxt = S_FIN;
        end else if (sts.multi) begin
          state_nxt = S_DSP_RD1;
        end else begin
          state_nxt = S_RM_DONE;
        end
      end
      S_DSP_RD1:  state_nxt = S_DSP_FIX;
      S_DSP_FIX:  state_nxt = sts.rm_start ? S_RM_RD : S_RM_DONE;
      S_RM_RD:    state_nxt = S_RM_WR;
      S_RM_WR:    state_nxt = sts.rm_more ? S_RM_RD : S_RM_DONE;
      S_RM_DONE:  state_nxt = sts.per_nz ? S_WALK_RD : S_FIN;
      S_FIN:      state_nxt = sts.out_free ? S_IDLE : S_FIN;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.act      = ACT_NONE;
    in_stall     = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:     cmd.act = in_valid ? ACT_ACCEPT : ACT_NONE;
      S_WALK_CMP: begin
        priority if (sts.walk_go) begin
          cmd.act = ACT_WALK_NEXT;
        end else if (sts.walk_in) begin
          cmd.act = ACT_WALK_STOP;
        end else begin
          cmd.act = ACT_PUT_NEW;
        end
      end
      S_SH_RD:    cmd.rd_src = 1'b1;
      S_SH_WR:    cmd.act = ACT_SHIFT_DN;
      S_PUT_HOLD: cmd.act = ACT_PUT_HOLD;
      S_PUT_NEW:  cmd.act = ACT_PUT_NEW;
      S_TICK_WR:  cmd.act = ACT_TICK;
      S_DSP_CHK:  cmd.act = ACT_DSP_TAKE;
      S_DSP_RD1:  cmd.rd_src = 1'b1;
      S_DSP_FIX:  cmd.act = ACT_DSP_FIX;
      S_RM_RD:    cmd.rd_src = 1'b1;
      S_RM_WR:    cmd.act = ACT_SHIFT_UP;
      S_RM_DONE:  cmd.act = ACT_REMOVE;
      S_FIN:      cmd.load_out = sts.out_free;
      default:    cmd.act = ACT_NONE;
    endcase
  end

  `DLTS_ASSERT(a_cmp_after_read, state_r == S_WALK_CMP |-> $past(state_r) == S_WALK_RD, "walk compare without a table read")
  `DLTS_ASSERT(a_idle_after_load, cmd.load_out |=> state_r == S_IDLE, "result loaded but sequencer not idle")
  `DLTS_ASSERT(a_shift_reads_src, (state_r == S_SH_WR || state_r == S_RM_WR) |-> $past(cmd.rd_src), "shift write without a source read")

endmodule

`default_nettype wire

FILE: hw/rtl/dlts_dp.sv
// ---------------------------------------------------------------------------
// dlts_dp
// task table, walk pointers, delay arithmetic and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dlts_dp #(
  parameter int MAX_TASKS = dlts_pkg::DLTS_MAX_TASKS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlts_pkg::in_req_t in_req,
  input  wire dlts_pkg::dp_cmd_t cmd,
  output dlts_pkg::dp_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dlts_pkg::out_rsp_t     out_rsp
);
  import dlts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CMP_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] src_r, src_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [7:0]       ins_handle_r, ins_handle_nxt;
  logic [31:0]      ins_period_r, ins_period_nxt;
  entry_t           hold_r, hold_nxt;
  out_rsp_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t           rd;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] src_w;
  logic [CMP_W-1:0] cnt_w;

  assign rd    = entry_t'(rd_data);
  assign raddr = cmd.rd_src ? src_r[IDX_W-1:0] : pos_r[IDX_W-1:0];
  assign pos_w = {1'b0, pos_r};
  assign src_w = {1'b0, src_r};
  assign cnt_w = {1'b0, count_r};

  dlts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_comb begin
    sts.full      = (count_r >= CNT_MAX);
    sts.cnt_zero  = (count_r == '0);
    sts.walk_in   = (pos_r < count_r);
    sts.walk_go   = sts.walk_in && (rem_r > rd.delay);
    sts.sh_first  = (cnt_w > pos_w + 1'b1);
    sts.sh_more   = (src_w > pos_w + 1'b1);
    sts.runs_zero = (rd.runs == '0);
    sts.multi     = (count_r > CNT_W'(1));
    sts.rm_start  = (count_r > CNT_W'(2));
    sts.rm_more   = (src_w + 1'b1 < cnt_w);
    sts.per_nz    = (ins_period_r != '0);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    src_nxt        = src_r;
    rem_nxt        = rem_r;
    ins_handle_nxt = ins_handle_r;
    ins_period_nxt = ins_period_r;
    hold_nxt       = hold_r;
    res_nxt        = res_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = rd;
    unique case (cmd.act)
      ACT_NONE: begin
      end
      ACT_ACCEPT: begin
        rem_nxt            = in_req.first_delay;
        ins_handle_nxt     = in_req.task_handle;
        ins_period_nxt     = in_req.repeat_period;
        pos_nxt            = '0;
        res_nxt.run_handle = '0;
        res_nxt.run_valid  = 1'b0;
        priority if (in_req.op == OP_ADD && sts.full) begin
          res_nxt.status = ST_FULL;
        end else if (in_req.op == OP_DISPATCH && sts.cnt_zero) begin
          res_nxt.status = ST_NONE;
        end else begin
          res_nxt.status = ST_DONE;
        end
      end
      ACT_WALK_NEXT: begin
        rem_nxt = rem_r - rd.delay;
        pos_nxt = pos_r + 1'b1;
      end
      ACT_WALK_STOP: begin
        hold_nxt       = rd;
        hold_nxt.delay = rd.delay - rem_r;
        src_nxt        = count_r - 1'b1;
      end
      ACT_SHIFT_DN: begin
        we      = 1'b1;
        waddr   = IDX_W'(src_r + 1'b1);
        src_nxt = src_r - 1'b1;
      end
      ACT_PUT_HOLD: begin
        we    = 1'b1;
        waddr = IDX_W'(pos_r + 1'b1);
        wdata = hold_r;
      end
      ACT_PUT_NEW: begin
        we           = 1'b1;
        waddr        = pos_r[IDX_W-1:0];
        wdata.handle = ins_handle_r;
        wdata.delay  = rem_r;
        wdata.period = ins_period_r;
        wdata.runs   = '0;
        count_nxt    = count_r + 1'b1;
      end
      ACT_TICK: begin
        we = 1'b1;
        priority if (rd.delay != '0) begin
          wdata.delay = rd.delay - 1'b1;
        end else if (rd.runs != RUNS_MAX) begin
          wdata.runs = rd.runs + 1'b1;
        end
      end
      ACT_DSP_TAKE: begin
        src_nxt = CNT_W'(1);
        if (rd.runs == '0) begin
          res_nxt.status = ST_NONE;
        end else begin
          ins_handle_nxt     = rd.handle;
          ins_period_nxt     = rd.period;
          rem_nxt            = rd.period;
          res_nxt.run_handle = rd.handle;
          res_nxt.run_valid  = 1'b1;
        end
      end
      ACT_DSP_FIX: begin
        we      = 1'b1;
        src_nxt = CNT_W'(2);
        if (rd.delay == '0 && rd.runs != RUNS_MAX) begin
          wdata.runs = rd.runs + 1'b1;
        end
      end
      ACT_SHIFT_UP: begin
        we      = 1'b1;
        waddr   = IDX_W'(src_r - 1'b1);
        src_nxt = src_r + 1'b1;
      end
      ACT_REMOVE: begin
        count_nxt = count_r - 1'b1;
        pos_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = res_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    src_r        <= src_nxt;
    rem_r        <= rem_nxt;
    ins_handle_r <= ins_handle_nxt;
    ins_period_r <= ins_period_nxt;
    hold_r       <= hold_nxt;
    res_r        <= res_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `DLTS_ASSERT(a_count_bound, count_r <= CNT_MAX, "task count beyond table depth")
  `DLTS_ASSERT(a_write_in_table, we |-> (CNT_W'(waddr) <= count_r), "table write past the filled part")
  `DLTS_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid_r || !out_stall), "pending result overwritten")
  `DLTS_ASSERT_NR(a_reset_clears_out, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

`default_nettype wire

FILE: hw/rtl/delta_list_task_scheduler.sv
// ---------------------------------------------------------------------------
// delta_list_task_scheduler
// cooperative task scheduler over a delay-sorted table of tasks
// ---------------------------------------------------------------------------
// usage:
//   in channel  : in_valid / in_stall / in_req, one request per op
//                 (add task, tick, dispatch); in_stall is high while a
//                 request is in progress
//   out channel : out_valid / out_stall / out_rsp, one result per request
// sequence: tick on an empty table, failed add, unused op or empty dispatch
//   go straight to the result; add walks the table, shifting later entries
//   down; a dispatch shifts the entries after the ready task up and re-adds
//   a periodic task by the add walk. the table gives one registered read per
//   cycle: each entry walked, shifted or moved takes a read state and then a
//   compare or write state. throughput: one request at a time, next one
//   taken the cycle after the result is registered
// reset: table empties (count to zero), no result pending
// stall: a finished result waits in the output register; the next request
//   is still taken, but its result keeps in_stall high until that register
//   can be loaded
// ---------------------------------------------------------------------------
`default_nettype none

module delta_list_task_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::DLTS_MAX_TASKS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dlts_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dlts_pkg::out_rsp_t      out_rsp
);
  import dlts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dlts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_req.op),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  dlts_dp #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

endmodule

`default_nettype wire
